// ===== hw/rtl/ahob_pkg.sv =====
// shared types, constants and table functions for the additive oscillator bank
package ahob_pkg;

    localparam int NUM_HARMONICS_DEF   = 16;
    localparam int MAX_FRAMES_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam logic [31:0] A4_INC_RESET     = 32'd39370534;
    localparam logic [24:0] ENV_STEP_RESET   = 25'd3495;
    localparam logic [5:0]  ENV_FRAMES_RESET = 6'd20;

    localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;
    localparam logic [1:0] REQ_WRITE    = 2'd3;

    localparam logic [1:0] REG_A4_INC     = 2'd0;
    localparam logic [1:0] REG_ENV_STEP   = 2'd1;
    localparam logic [1:0] REG_ENV_FRAMES = 2'd2;

    localparam logic [15:0] AMP_ONE = 16'd32768;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  note_number;
        logic [4:0]  frame_index;
        logic [3:0]  harmonic_index;
        logic [15:0] amplitude;
    } t_in;

    typedef struct packed {
        logic signed [23:0] sample_out;
        logic               voice_active;
    } t_out;

    function automatic logic [15:0] semitone(input logic [3:0] k);
        logic [15:0] v;
        case (k)
            4'd0:    v = 16'd32768;
            4'd1:    v = 16'd34716;
            4'd2:    v = 16'd36781;
            4'd3:    v = 16'd38968;
            4'd4:    v = 16'd41285;
            4'd5:    v = 16'd43740;
            4'd6:    v = 16'd46341;
            4'd7:    v = 16'd49097;
            4'd8:    v = 16'd52016;
            4'd9:    v = 16'd55109;
            4'd10:   v = 16'd58386;
            4'd11:   v = 16'd61858;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] taylor(input int i);
        logic [63:0] v;
        case (i)
            0:       v = 64'd1686629713;
            1:       v = 64'd693598669;
            2:       v = 64'd85569309;
            3:       v = 64'd5026995;
            default: v = 64'd172272;
        endcase
        return v;
    endfunction

    // quarter-wave sine entry, evaluated at elaboration
    function automatic logic [15:0] qsine(input int k, input int bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        x  = 64'(k) << (32 - bits);
        x2 = (x * x) >> 30;
        p  = taylor(4);
        for (int i = 3; i >= 0; i--) begin
            p = taylor(i) - ((x2 * p) >> 30);
        end
        s = (x * p) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[15:0];
    endfunction

endpackage

// ===== hw/rtl/ahob_ram.sv =====
// generic single write port ram with registered read
module ahob_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/additive_harmonic_oscillator_bank.sv =====
// top level of the additive oscillator bank voice
// One voice. A table write or note-off stays in idle, a note-on passes S_NMUL and
// S_NSET, a silent tick goes to S_OUT. A sounding tick runs S_RD0-S_ACC per harmonic,
// then S_WRAP until no envelope wrap is due and S_OUT. Every harmonic makes two reads
// of the single read port of the envelope ram and two passes through the one shared
// 34x18 multiplier, which also forms the base increment on note-on. The input stalls
// while a transaction is in work; a finished sample waits in the output register.
module additive_harmonic_oscillator_bank #(
    parameter int NUM_HARMONICS   = ahob_pkg::NUM_HARMONICS_DEF,
    parameter int MAX_FRAMES      = ahob_pkg::MAX_FRAMES_DEF,
    parameter int SINE_TABLE_BITS = ahob_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ahob_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ahob_pkg::t_out  o_out,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int HW    = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 1;
    localparam int FW    = $clog2(MAX_FRAMES);
    localparam int DEPTH = MAX_FRAMES * NUM_HARMONICS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = 25 + FW;
    localparam int QS    = 1 << (SINE_TABLE_BITS - 2);
    localparam int SB    = SINE_TABLE_BITS;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_NMUL = 10'b0000000010,
        S_NSET = 10'b0000000100,
        S_RD0  = 10'b0000001000,
        S_RD1  = 10'b0000010000,
        S_INT  = 10'b0000100000,
        S_SIN  = 10'b0001000000,
        S_ACC  = 10'b0010000000,
        S_WRAP = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state;

    logic [31:0] r_a4;
    logic [24:0] r_env_step;
    logic [5:0]  r_env_frames;

    logic [31:0]          r_phase [NUM_HARMONICS];
    logic [31:0]          r_base;
    logic [31:0]          r_step;
    logic                 r_active;
    logic [PW-1:0]        r_pos;
    logic [HW-1:0]        r_h;
    logic [FW-1:0]        r_f0;
    logic [FW-1:0]        r_f1;
    logic [15:0]          r_a0;
    logic signed [51:0]   r_prod;
    logic signed [39:0]   r_acc;
    logic [3:0]           r_k;
    logic [4:0]           r_shift;
    ahob_pkg::t_out       r_res;
    ahob_pkg::t_out       r_out;
    logic                 r_ovalid;

    logic                 w_accept;
    logic                 w_cfg_we;
    logic [FW:0]          w_frames;
    logic [PW-1:0]        w_limit;
    logic [FW:0]          w_f0;
    logic [FW:0]          w_f1;
    logic [7:0]           w_m;
    logic [13:0]          w_m43;
    logic [3:0]           w_q;
    logic [7:0]           w_r;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [15:0]          w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [15:0]          w_rdata;
    logic signed [33:0]   w_mul_a;
    logic signed [17:0]   w_mul_b;
    logic signed [51:0]   w_prod;
    logic signed [17:0]   w_amp;
    logic signed [16:0]   w_diff;
    logic [15:0]          w_qs [QS+1];
    logic [SB-1:0]        w_idx;
    logic [SB-2:0]        w_j;
    logic signed [15:0]   w_sv;
    logic signed [15:0]   w_sine;
    logic signed [28:0]   w_shr;
    logic signed [23:0]   w_sat;
    logic [47:0]          w_base_full;

    for (genvar k = 0; k <= QS; k++) begin : g_qs
        assign w_qs[k] = ahob_pkg::qsine(k, SB);
    end

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            ahob_pkg::REG_A4_INC:     prdata = r_a4;
            ahob_pkg::REG_ENV_STEP:   prdata = {7'd0, r_env_step};
            ahob_pkg::REG_ENV_FRAMES: prdata = {26'd0, r_env_frames};
            default:                  prdata = 32'd0;
        endcase
    end

    // envelope frame selection
    always_comb begin
        if (r_env_frames == 6'd0) begin
            w_frames = (FW+1)'(1);
        end else if (32'(r_env_frames) > 32'(MAX_FRAMES)) begin
            w_frames = (FW+1)'(MAX_FRAMES);
        end else begin
            w_frames = (FW+1)'(r_env_frames);
        end
        w_limit = PW'(w_frames) << 24;
        w_f0    = r_pos[PW-1:24];
        if (w_f0 >= w_frames) begin
            w_f0 = w_frames - (FW+1)'(1);
        end
        w_f1 = w_f0 + (FW+1)'(1);
        if (w_f1 >= w_frames) begin
            w_f1 = '0;
        end
    end

    // note number to semitone and octave shift, m/12 by reciprocal
    assign w_m   = {1'b0, i_in.note_number} + 8'd3;
    assign w_m43 = 14'(w_m) * 14'd43;
    assign w_q   = w_m43[12:9];
    assign w_r   = w_m - 8'(w_q) * 8'd12;

    assign w_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // table write port
    assign w_we    = w_accept && (i_in.req_type == ahob_pkg::REQ_WRITE)
                     && (32'(i_in.frame_index) < 32'(MAX_FRAMES))
                     && (32'(i_in.harmonic_index) < 32'(NUM_HARMONICS));
    assign w_waddr = AW'(i_in.frame_index) * AW'(NUM_HARMONICS) + AW'(i_in.harmonic_index);
    assign w_wdata = (i_in.amplitude > ahob_pkg::AMP_ONE) ? ahob_pkg::AMP_ONE
                                                          : i_in.amplitude;
    assign w_raddr = (r_state == S_RD1)
                     ? AW'(r_f1) * AW'(NUM_HARMONICS) + AW'(r_h)
                     : AW'(r_f0) * AW'(NUM_HARMONICS) + AW'(r_h);

    ahob_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_env_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sine lookup of the current harmonic
    always_comb begin
        w_idx = r_phase[r_h][31 -: SB];
        w_j   = (SB-1)'(w_idx[SB-3:0]);
        if (w_idx[SB-2]) begin
            w_sv = $signed(w_qs[(SB-1)'(QS) - w_j]);
        end else begin
            w_sv = $signed(w_qs[w_j]);
        end
        w_sine = w_idx[SB-1] ? -w_sv : w_sv;
    end

    // shared multiplier
    assign w_diff = $signed({1'b0, w_rdata}) - $signed({1'b0, r_a0});
    assign w_amp  = $signed({2'b00, r_a0}) + $signed(r_prod[41:24]);

    always_comb begin
        case (r_state)
            S_NMUL: begin
                w_mul_a = $signed({2'b00, r_a4});
                w_mul_b = $signed({2'b00, ahob_pkg::semitone(r_k)});
            end
            S_INT: begin
                w_mul_a = $signed({10'd0, r_pos[23:0]});
                w_mul_b = 18'(w_diff);
            end
            S_SIN: begin
                w_mul_a = 34'(w_amp);
                w_mul_b = 18'(w_sine);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod      = w_mul_a * w_mul_b;
    assign w_base_full = 48'(r_prod) >> r_shift;

    // output scaling and saturation
    always_comb begin
        w_shr = 29'(r_acc >>> 11);
        if (w_shr > 29'sd8388607) begin
            w_sat = 24'sd8388607;
        end else if (w_shr < -29'sd8388608) begin
            w_sat = -24'sd8388608;
        end else begin
            w_sat = 24'(w_shr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_a4         <= ahob_pkg::A4_INC_RESET;
            r_env_step   <= ahob_pkg::ENV_STEP_RESET;
            r_env_frames <= ahob_pkg::ENV_FRAMES_RESET;
            r_base       <= '0;
            r_active     <= 1'b0;
            r_pos        <= '0;
            r_ovalid     <= 1'b0;
            for (int i = 0; i < NUM_HARMONICS; i++) begin
                r_phase[i] <= '0;
            end
        end else begin
            if (w_cfg_we) begin
                case (paddr[3:2])
                    ahob_pkg::REG_A4_INC:     r_a4 <= pwdata;
                    ahob_pkg::REG_ENV_STEP:   r_env_step <= pwdata[24:0];
                    ahob_pkg::REG_ENV_FRAMES: r_env_frames <= pwdata[5:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_out_stall && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            r_prod <= w_prod;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in.req_type)
                            ahob_pkg::REQ_NOTE_ON: begin
                                r_k     <= w_r[3:0];
                                r_shift <= 5'd21 - 5'(w_q);
                                r_state <= S_NMUL;
                            end
                            ahob_pkg::REQ_NOTE_OFF: begin
                                r_active <= 1'b0;
                            end
                            ahob_pkg::REQ_TICK: begin
                                if (r_active) begin
                                    r_f0    <= FW'(w_f0);
                                    r_f1    <= FW'(w_f1);
                                    r_h     <= '0;
                                    r_acc   <= '0;
                                    r_step  <= r_base;
                                    r_state <= S_RD0;
                                end else begin
                                    r_res   <= '0;
                                    r_state <= S_OUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_NMUL: begin
                    r_state <= S_NSET;
                end
                S_NSET: begin
                    r_base   <= w_base_full[31:0];
                    r_pos    <= '0;
                    r_active <= 1'b1;
                    for (int i = 0; i < NUM_HARMONICS; i++) begin
                        r_phase[i] <= '0;
                    end
                    r_state <= S_IDLE;
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_a0    <= w_rdata;
                    r_state <= S_INT;
                end
                S_INT: begin
                    r_state <= S_SIN;
                end
                S_SIN: begin
                    r_phase[r_h] <= r_phase[r_h] + r_step;
                    r_step       <= r_step + r_base;
                    r_state      <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_acc + 40'(r_prod);
                    if (r_h == HW'(NUM_HARMONICS - 1)) begin
                        r_pos   <= r_pos + PW'(r_env_step);
                        r_state <= S_WRAP;
                    end else begin
                        r_h     <= r_h + HW'(1);
                        r_state <= S_RD0;
                    end
                end
                S_WRAP: begin
                    if (r_pos >= w_limit) begin
                        r_pos <= r_pos - w_limit;
                    end else begin
                        r_res.sample_out   <= w_sat;
                        r_res.voice_active <= 1'b1;
                        r_state            <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule
